// ----- hw/rtl/wht_pkg.sv -----
// Shared types, codes and constants for the water heater thermostat.
// Used by wht_avg and water_heater_thermostat; no dependencies.
package wht_pkg;

  // op codes carried in s_tuser
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_UP    = 2'd1;
  localparam logic [1:0] OP_DOWN  = 2'd2;
  localparam logic [1:0] OP_POWER = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_BAND_HALF_WIDTH    = 3'd0;
  localparam logic [2:0] CFG_SAMPLE_TICKS       = 3'd1;
  localparam logic [2:0] CFG_BLINK_TICKS        = 3'd2;
  localparam logic [2:0] CFG_EDIT_TIMEOUT_TICKS = 3'd3;
  localparam logic [2:0] CFG_IDLE_OFF_TICKS     = 3'd4;

  localparam logic [4:0]  RST_BAND_HALF_WIDTH    = 5'd5;
  localparam logic [7:0]  RST_SAMPLE_TICKS       = 8'd25;
  localparam logic [7:0]  RST_BLINK_TICKS        = 8'd125;
  localparam logic [11:0] RST_EDIT_TIMEOUT_TICKS = 12'd1250;
  localparam logic [15:0] RST_IDLE_OFF_TICKS     = 16'd60000;

  localparam logic [6:0] SP_RESET = 7'd60;
  localparam logic [6:0] SP_MIN   = 7'd35;
  localparam logic [6:0] SP_MAX   = 7'd75;
  localparam logic [6:0] SP_STEP  = 7'd5;

  localparam logic [3:0] DIGIT_BLANK = 4'd10;
  localparam logic [7:0] SHOW_MAX    = 8'd99;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_AVG,
    ST_FINISH
  } ctl_state_t;

  typedef enum logic [1:0] {
    AVG_IDLE,
    AVG_SUM,
    AVG_DIV
  } avg_state_t;

  typedef struct packed {
    logic wr_en;
    logic start;
  } avg_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } avg_sts_t;

  typedef struct packed {
    logic [3:0] ones;
    logic [3:0] tens;
  } digits_t;

  // Two display digits of a value; anything over 99 shows as 9 9.
  // v/10 for v < 256 is (v*205) >> 11.
  function automatic digits_t show_digits(input logic [7:0] v);
    digits_t    d;
    logic [15:0] prod;
    logic [3:0]  t;
    logic [7:0]  r;
    prod = 16'(v) * 16'd205;
    t    = prod[14:11];
    r    = v - 8'(t) * 8'd10;
    if (v > SHOW_MAX) begin
      d.tens = 4'd9;
      d.ones = 4'd9;
    end else begin
      d.tens = t;
      d.ones = r[3:0];
    end
    return d;
  endfunction

endpackage

// ----- hw/rtl/water_heater_thermostat.sv -----
// Water heater thermostat controller, top level.
// Depends on wht_pkg and wht_avg.
//
// Input channel s_*: one item per 4 ms tick or button press. s_tuser holds
// the op code, s_tdata the raw sensor reading. Output channel m_*: exactly
// one result item per input item: display digits, lamps and drives.
// Configuration: cfg_we/cfg_addr/cfg_data write one register per cycle;
// write only while no item is in flight.
//
// Flow: an item is taken in ST_IDLE and its result is registered in
// ST_FINISH, which waits while the output register holds an untaken result.
// An item that completes a block of AVG_SAMPLES samples passes ST_AVG first:
// the stored samples are summed one per cycle through the single adder in
// wht_avg, and the mean is formed by one multiply by the reciprocal of the
// sample count. s_tready is high only while the sequencer is idle.
//
// A finished result sits in the output register until taken; the next item
// is accepted meanwhile, and its result waits in the last step while m_tready
// is low. Reset (rst, synchronous) clears all control state, turns the unit
// off with setpoint 60 and restores register defaults. The sample store
// holds no reset value; a full block is written before it is read.
module water_heater_thermostat
  import wht_pkg::*;
#(
  parameter int AVG_SAMPLES = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] adc_value, [15:10] zero
  input  logic [1:0]  s_tuser,   // [1:0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [3:0] tens_digit, [7:4] ones_digit, [8] power_lamp,
                                 // [9] heater_drive, [10] cooler_drive, [11] status_lamp,
                                 // [12] editing, [15:13] zero
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

  localparam int IDX_W = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
  localparam logic [IDX_W:0] N_IDX = (IDX_W + 1)'(AVG_SAMPLES);

  // configuration
  logic [4:0]  band_half_width;
  logic [7:0]  sample_ticks;
  logic [7:0]  blink_ticks;
  logic [11:0] edit_timeout_ticks;
  logic [15:0] idle_off_ticks;

  // controller state
  ctl_state_t state, state_next;
  logic        power_on, power_on_next;
  logic        edit_mode, edit_mode_next;
  logic        timer_running, timer_running_next;
  logic [6:0]  setpoint, setpoint_next;
  logic [7:0]  tank_temp, tank_temp_next;
  logic [IDX_W-1:0] sample_index, sample_index_next;
  logic [7:0]  sample_tick_count, sample_tick_count_next;
  logic [11:0] edit_tick_count, edit_tick_count_next;
  logic [7:0]  blink_tick_count, blink_tick_count_next;
  logic        blink_phase, blink_phase_next;
  logic        heating_flag, heating_flag_next;
  logic        cooling_flag, cooling_flag_next;
  logic        at_target_flag, at_target_flag_next;
  logic [15:0] at_target_ticks, at_target_ticks_next;
  digits_t     digits, digits_next;
  logic        lamp_state, lamp_state_next;
  logic [7:0]  temp_now;
  logic [7:0]  temp_now_next;
  logic        m_tvalid_next;
  logic [15:0] m_tdata_next;

  logic        accept;
  logic        out_free;
  logic [1:0]  op;
  logic        tick_inc;
  logic [7:0]  stc_new;
  logic        samp_fire;
  logic [IDX_W:0] idx_inc;
  logic        avg_go;
  logic [7:0]  band_hi;
  logic [7:0]  band_lo;

  avg_ctl_t    avg_ctl;
  avg_sts_t    avg_sts;
  logic [7:0]  avg_mean;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign op       = s_tuser;

  assign tick_inc  = (op == OP_TICK) && timer_running;
  assign stc_new   = tick_inc ? sample_tick_count + 8'd1 : sample_tick_count;
  assign samp_fire = (stc_new >= sample_ticks);
  assign idx_inc   = {1'b0, sample_index} + 1'b1;
  assign avg_go    = samp_fire && (idx_inc == N_IDX);

  assign avg_ctl.wr_en = accept && samp_fire;
  assign avg_ctl.start = accept && avg_go;

  assign band_hi = 8'(setpoint) + 8'(band_half_width);
  assign band_lo = 8'(setpoint) - 8'(band_half_width);

  wht_avg #(
    .AVG_SAMPLES(AVG_SAMPLES)
  ) u_avg (
    .clk     (clk),
    .rst     (rst),
    .ctl     (avg_ctl),
    .wr_addr (sample_index),
    .wr_data (s_tdata[9:2]),
    .sts     (avg_sts),
    .mean    (avg_mean)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = avg_go ? ST_AVG : ST_FINISH;
      ST_AVG:    if (avg_sts.done) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    power_on_next          = power_on;
    edit_mode_next         = edit_mode;
    timer_running_next     = timer_running;
    setpoint_next          = setpoint;
    tank_temp_next         = tank_temp;
    sample_index_next      = sample_index;
    sample_tick_count_next = sample_tick_count;
    edit_tick_count_next   = edit_tick_count;
    blink_tick_count_next  = blink_tick_count;
    blink_phase_next       = blink_phase;
    heating_flag_next      = heating_flag;
    cooling_flag_next      = cooling_flag;
    at_target_flag_next    = at_target_flag;
    at_target_ticks_next   = at_target_ticks;
    digits_next            = digits;
    lamp_state_next        = lamp_state;
    temp_now_next          = temp_now;
    m_tvalid_next          = m_tvalid && !m_tready;
    m_tdata_next           = m_tdata;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          temp_now_next          = s_tdata[9:2];
          sample_tick_count_next = stc_new;
          if (tick_inc) begin
            if (edit_mode) begin
              edit_tick_count_next  = edit_tick_count + 12'd1;
              blink_tick_count_next = blink_tick_count + 8'd1;
            end else if (power_on) begin
              if (heating_flag) blink_tick_count_next = blink_tick_count + 8'd1;
              else if (at_target_flag) at_target_ticks_next = at_target_ticks + 16'd1;
            end
          end

          if (!power_on) begin
            tank_temp_next      = s_tdata[9:2];
            heating_flag_next   = 1'b0;
            cooling_flag_next   = 1'b0;
            at_target_flag_next = 1'b0;
            lamp_state_next     = 1'b0;
            if (op == OP_UP || op == OP_DOWN) begin
              // first press only opens edit mode
              if (!edit_mode) begin
                edit_mode_next     = 1'b1;
                timer_running_next = 1'b1;
              end else if (op == OP_UP) begin
                if (setpoint < SP_MAX) setpoint_next = setpoint + SP_STEP;
              end else begin
                if (setpoint > SP_MIN) setpoint_next = setpoint - SP_STEP;
              end
              edit_tick_count_next = '0;
            end
          end

          if (op == OP_POWER) begin
            power_on_next = !power_on;
            if (!power_on) begin
              timer_running_next   = 1'b1;
              edit_mode_next       = 1'b0;
              edit_tick_count_next = '0;
            end
          end

          if (samp_fire) begin
            sample_index_next      = avg_go ? '0 : idx_inc[IDX_W-1:0];
            sample_tick_count_next = '0;
          end

          if (edit_mode_next && edit_tick_count_next >= edit_timeout_ticks) begin
            edit_mode_next       = 1'b0;
            power_on_next        = 1'b1;
            edit_tick_count_next = '0;
            timer_running_next   = 1'b1;
          end

          if (blink_tick_count_next >= blink_ticks) begin
            if (edit_mode_next) begin
              if (!blink_phase) begin
                digits_next      = show_digits({1'b0, setpoint_next});
                blink_phase_next = 1'b1;
              end else begin
                digits_next.tens = DIGIT_BLANK;
                digits_next.ones = DIGIT_BLANK;
                blink_phase_next = 1'b0;
              end
            end else if (heating_flag_next && power_on_next) begin
              lamp_state_next = !lamp_state_next;
            end
            blink_tick_count_next = '0;
          end
          if (cooling_flag_next && power_on_next) lamp_state_next = 1'b1;

          if (at_target_ticks_next >= idle_off_ticks) begin
            power_on_next        = 1'b0;
            at_target_ticks_next = '0;
          end

          if (!power_on_next && !edit_mode_next) begin
            digits_next        = show_digits({1'b0, setpoint_next});
            timer_running_next = 1'b0;
          end
        end
      end

      ST_AVG: begin
        if (avg_sts.done) tank_temp_next = avg_mean;
      end

      ST_FINISH: begin
        if (out_free) begin
          if (power_on) begin
            digits_next = show_digits(tank_temp);
            if (tank_temp < band_hi && tank_temp > band_lo &&
                !cooling_flag && !heating_flag && !at_target_flag) begin
              at_target_flag_next  = 1'b1;
              at_target_ticks_next = '0;
            end else if ((tank_temp == band_hi && heating_flag) ||
                         (cooling_flag && tank_temp == band_lo)) begin
              lamp_state_next      = 1'b0;
              heating_flag_next    = 1'b0;
              cooling_flag_next    = 1'b0;
              at_target_flag_next  = 1'b1;
              at_target_ticks_next = '0;
            end else if (tank_temp < band_lo) begin
              heating_flag_next    = 1'b1;
              cooling_flag_next    = 1'b0;
              at_target_ticks_next = '0;
            end else if (tank_temp > band_hi) begin
              cooling_flag_next    = 1'b1;
              heating_flag_next    = 1'b0;
              at_target_ticks_next = '0;
            end
          end else begin
            tank_temp_next      = temp_now;
            heating_flag_next   = 1'b0;
            cooling_flag_next   = 1'b0;
            at_target_flag_next = 1'b0;
            lamp_state_next     = 1'b0;
          end
          m_tvalid_next = 1'b1;
          m_tdata_next  = {3'b000, edit_mode, lamp_state_next, cooling_flag_next,
                           heating_flag_next, power_on, digits_next.ones, digits_next.tens};
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      band_half_width    <= RST_BAND_HALF_WIDTH;
      sample_ticks       <= RST_SAMPLE_TICKS;
      blink_ticks        <= RST_BLINK_TICKS;
      edit_timeout_ticks <= RST_EDIT_TIMEOUT_TICKS;
      idle_off_ticks     <= RST_IDLE_OFF_TICKS;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_BAND_HALF_WIDTH:    band_half_width    <= cfg_data[4:0];
        CFG_SAMPLE_TICKS:       sample_ticks       <= cfg_data[7:0];
        CFG_BLINK_TICKS:        blink_ticks        <= cfg_data[7:0];
        CFG_EDIT_TIMEOUT_TICKS: edit_timeout_ticks <= cfg_data[11:0];
        CFG_IDLE_OFF_TICKS:     idle_off_ticks     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      power_on          <= 1'b0;
      edit_mode         <= 1'b0;
      timer_running     <= 1'b0;
      setpoint          <= SP_RESET;
      tank_temp         <= '0;
      sample_index      <= '0;
      sample_tick_count <= '0;
      edit_tick_count   <= '0;
      blink_tick_count  <= '0;
      blink_phase       <= 1'b0;
      heating_flag      <= 1'b0;
      cooling_flag      <= 1'b0;
      at_target_flag    <= 1'b0;
      at_target_ticks   <= '0;
      digits.tens       <= 4'd6;
      digits.ones       <= 4'd0;
      lamp_state        <= 1'b0;
      m_tvalid          <= 1'b0;
    end else begin
      state             <= state_next;
      power_on          <= power_on_next;
      edit_mode         <= edit_mode_next;
      timer_running     <= timer_running_next;
      setpoint          <= setpoint_next;
      tank_temp         <= tank_temp_next;
      sample_index      <= sample_index_next;
      sample_tick_count <= sample_tick_count_next;
      edit_tick_count   <= edit_tick_count_next;
      blink_tick_count  <= blink_tick_count_next;
      blink_phase       <= blink_phase_next;
      heating_flag      <= heating_flag_next;
      cooling_flag      <= cooling_flag_next;
      at_target_flag    <= at_target_flag_next;
      at_target_ticks   <= at_target_ticks_next;
      digits            <= digits_next;
      lamp_state        <= lamp_state_next;
      m_tvalid          <= m_tvalid_next;
    end
    temp_now <= temp_now_next;
    m_tdata  <= m_tdata_next;
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted item did not start the sequencer");

  a_finish_drives_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_free) |=> m_tvalid && state == ST_IDLE)
    else $error("finished item did not reach the output register");

  a_avg_busy_while_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ST_AVG && !avg_sts.done) |-> avg_sts.busy)
    else $error("waiting for the mean while the averaging unit is idle");

  a_setpoint_range: assert property (@(posedge clk) disable iff (rst)
    setpoint >= SP_MIN && setpoint <= SP_MAX)
    else $error("setpoint left its range");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, sample_index} < N_IDX)
    else $error("sample index past the sample count");

endmodule

// ----- hw/rtl/wht_avg.sv -----
// Sample store and averaging unit: one adder sums the stored samples one per
// cycle, then a multiply by the reciprocal of the sample count gives the mean.
// Depends on wht_pkg.
module wht_avg
  import wht_pkg::*;
#(
  parameter int AVG_SAMPLES = 10
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  avg_ctl_t                                         ctl,
  input  logic [((AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1)-1:0] wr_addr,
  input  logic [7:0]                                       wr_data,
  output avg_sts_t                                         sts,
  output logic [7:0]                                       mean
);

  localparam int IDX_W  = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
  localparam int CNT_W  = $clog2(AVG_SAMPLES + 1);
  localparam int SUM_W  = 8 + $clog2(AVG_SAMPLES);
  // mean = (sum * RECIP) >> SHIFT, exact for every sum below 2**SUM_W
  localparam int SHIFT  = SUM_W + $clog2(AVG_SAMPLES);
  localparam int RCP_W  = SUM_W + 1;
  localparam int PROD_W = SUM_W + RCP_W;
  localparam int RECIP_I = ((1 << SHIFT) + AVG_SAMPLES - 1) / AVG_SAMPLES;
  localparam logic [CNT_W-1:0] N_CNT = CNT_W'(AVG_SAMPLES);
  localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_I);

  logic [7:0] store [AVG_SAMPLES];

  avg_state_t       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [SUM_W-1:0] acc, acc_next;
  logic [7:0]       quo, quo_next;
  logic [7:0]       mem_q;
  logic             done;

  // single adder and reciprocal multiply
  logic [SUM_W-1:0]  alu_res;
  logic [PROD_W-1:0] prod;

  assign alu_res = acc + SUM_W'(mem_q);
  assign prod    = PROD_W'(acc) * PROD_W'(RECIP);

  always_comb begin
    state_next = state;
    case (state)
      AVG_IDLE: if (ctl.start) state_next = AVG_SUM;
      AVG_SUM:  if (cnt == N_CNT) state_next = AVG_DIV;
      AVG_DIV:  state_next = AVG_IDLE;
      default:  state_next = AVG_IDLE;
    endcase
  end

  always_comb begin
    cnt_next = cnt;
    acc_next = acc;
    quo_next = quo;
    case (state)
      AVG_IDLE: begin
        if (ctl.start) begin
          cnt_next = '0;
          acc_next = '0;
        end
      end
      AVG_SUM: begin
        // read data is registered, so it arrives in the cycle after its address
        if (cnt != '0) acc_next = alu_res;
        if (cnt != N_CNT) cnt_next = cnt + 1'b1;
      end
      AVG_DIV: begin
        quo_next = prod[SHIFT +: 8];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) store[wr_addr] <= wr_data;
    if (state == AVG_SUM && cnt < N_CNT) mem_q <= store[cnt[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AVG_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == AVG_DIV);
    end
    cnt <= cnt_next;
    acc <= acc_next;
    quo <= quo_next;
  end

  assign sts.busy = (state != AVG_IDLE);
  assign sts.done = done;
  assign mean     = quo;

endmodule
